// ===== hdl/rvsc_pkg.sv =====
package rvsc_pkg;

  // Major opcodes handled by the core
  localparam logic [6:0] OPC_OPIMM = 7'b0010011;
  localparam logic [6:0] OPC_JALR  = 7'b1100111;
  localparam logic [6:0] OPC_OP    = 7'b0110011;
  localparam logic [6:0] OPC_LUI   = 7'b0110111;
  localparam logic [6:0] OPC_LOAD  = 7'b0000011;
  localparam logic [6:0] OPC_STORE = 7'b0100011;

  localparam int XLEN  = 32;
  localparam int IN_W  = 32;
  localparam int OUT_W = 136;

  // What one instruction leaves behind once executed (load data still to come)
  typedef struct packed {
    logic [XLEN-1:0] fetch_address;
    logic            reg_write;
    logic            is_load;
    logic [XLEN-1:0] reg_value;
    logic            mem_write;
    logic [XLEN-1:0] mem_address;
    logic [XLEN-1:0] mem_value;
  } exec_res_t;

  // Forwarding view of one later pipeline stage
  typedef struct packed {
    logic            hit_a;
    logic            hit_b;
    logic            pending;
    logic [XLEN-1:0] value;
  } fwd_t;

  // Stage advance and access strobes for the data memory path
  typedef struct packed {
    logic adv2;
    logic adv3;
    logic adv4;
    logic load;
    logic store;
  } dmem_ctl_t;

endpackage

// ===== hdl/rvsc_regfile.sv =====
module rvsc_regfile #(
  parameter int REG_COUNT = 16,
  localparam int RIDX_W = $clog2(REG_COUNT)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [RIDX_W-1:0] rs1_in,
  input  logic [RIDX_W-1:0] rs2_in,
  input  logic [RIDX_W-1:0] rs1_q,
  input  logic [RIDX_W-1:0] rs2_q,
  input  logic              wr_en,
  input  logic [RIDX_W-1:0] wr_idx,
  input  logic [31:0]       wr_data,
  output logic [31:0]       op_a,
  output logic [31:0]       op_b
);
  import rvsc_pkg::*;

  logic [XLEN-1:0]      regs [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [XLEN-1:0]      fresh_a;
  logic [XLEN-1:0]      fresh_b;
  logic [XLEN-1:0]      op_a_next;
  logic [XLEN-1:0]      op_b_next;

  // Mark entries as written; an unwritten entry (and register zero) reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      regs[wr_idx] <= wr_data;
    end
  end

  // Read with write-first bypass
  always_comb begin
    fresh_a = valid[rs1_in] ? regs[rs1_in] : '0;
    fresh_b = valid[rs2_in] ? regs[rs2_in] : '0;
    if (wr_en && wr_idx == rs1_in) fresh_a = wr_data;
    if (wr_en && wr_idx == rs2_in) fresh_b = wr_data;
  end

  // Capture operands on a new item, otherwise track writes to the held sources
  always_comb begin
    op_a_next = op_a;
    op_b_next = op_b;
    if (load) begin
      op_a_next = fresh_a;
      op_b_next = fresh_b;
    end else begin
      if (wr_en && wr_idx == rs1_q) op_a_next = wr_data;
      if (wr_en && wr_idx == rs2_q) op_b_next = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    op_a <= op_a_next;
    op_b <= op_b_next;
  end

endmodule

// ===== hdl/rvsc_execute.sv =====
module rvsc_execute (
  input  logic [31:0]          inst,
  input  logic [31:0]          pc,
  input  logic [31:0]          op_a,
  input  logic [31:0]          op_b,
  input  logic                 rd_zero,
  input  rvsc_pkg::fwd_t       f2,
  input  rvsc_pkg::fwd_t       f3,
  input  rvsc_pkg::fwd_t       f4,
  output rvsc_pkg::exec_res_t  res,
  output logic                 hazard
);
  import rvsc_pkg::*;

  logic [6:0]      opc;
  logic [XLEN-1:0] a;
  logic [XLEN-1:0] b;
  logic            wait_a;
  logic            wait_b;
  logic            uses_a;
  logic            uses_b;
  logic [XLEN-1:0] imm_i;
  logic [XLEN-1:0] imm_s;
  logic [XLEN-1:0] sum;
  logic [XLEN-1:0] pc_plus4;

  assign opc      = inst[6:0];
  assign imm_i    = {{20{inst[31]}}, inst[31:20]};
  assign imm_s    = {{20{inst[31]}}, inst[31:25], inst[11:7]};
  assign pc_plus4 = pc + 32'd4;

  // Pick the newest in-flight value of each source; a load still in flight must wait
  always_comb begin
    a      = op_a;
    wait_a = 1'b0;
    if (f2.hit_a) begin
      a      = f2.value;
      wait_a = f2.pending;
    end else if (f3.hit_a) begin
      a      = f3.value;
      wait_a = f3.pending;
    end else if (f4.hit_a) begin
      a = f4.value;
    end
    b      = op_b;
    wait_b = 1'b0;
    if (f2.hit_b) begin
      b      = f2.value;
      wait_b = f2.pending;
    end else if (f3.hit_b) begin
      b      = f3.value;
      wait_b = f3.pending;
    end else if (f4.hit_b) begin
      b = f4.value;
    end
  end

  // Which sources the opcode actually reads
  always_comb begin
    uses_a = 1'b0;
    uses_b = 1'b0;
    case (opc)
      OPC_OPIMM, OPC_JALR, OPC_LOAD: uses_a = 1'b1;
      OPC_OP, OPC_STORE: begin
        uses_a = 1'b1;
        uses_b = 1'b1;
      end
      default: ;
    endcase
  end

  assign hazard = (uses_a && wait_a) || (uses_b && wait_b);

  // Shared address / immediate adder
  assign sum = a + ((opc == OPC_STORE) ? imm_s : imm_i);

  always_comb begin
    res               = '0;
    res.fetch_address = pc_plus4;
    case (opc)
      OPC_OPIMM: begin
        res.reg_write = 1'b1;
        res.reg_value = sum;
      end
      OPC_OP: begin
        res.reg_write = 1'b1;
        res.reg_value = a + b;
      end
      OPC_LUI: begin
        res.reg_write = 1'b1;
        res.reg_value = {inst[31:12], 12'd0};
      end
      OPC_JALR: begin
        res.reg_write     = 1'b1;
        res.reg_value     = pc_plus4;
        res.fetch_address = {sum[31:1], 1'b0};
      end
      OPC_LOAD: begin
        res.reg_write   = 1'b1;
        res.is_load     = 1'b1;
        res.mem_address = sum;
      end
      OPC_STORE: begin
        res.mem_write   = 1'b1;
        res.mem_address = sum;
        res.mem_value   = b;
      end
      default: ;
    endcase
    // Drop writes to register zero
    if (rd_zero) begin
      res.reg_write = 1'b0;
      res.is_load   = 1'b0;
      res.reg_value = '0;
    end
  end

endmodule

// ===== hdl/rvsc_dmem.sv =====
module rvsc_dmem #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rvsc_pkg::dmem_ctl_t   ctl,
  input  logic [31:0]           addr,
  input  logic [31:0]           wdata,
  output logic [31:0]           mem_q,
  output logic                  clear_done
);
  import rvsc_pkg::*;

  // Word index = (addr >> 2) mod MEM_WORDS by reciprocal multiply over two stages
  localparam int WORD_W = 30;
  localparam int MIDX_W = $clog2(MEM_WORDS);
  localparam int MW_W   = $clog2(MEM_WORDS + 1);
  localparam int SHIFT  = WORD_W + MIDX_W;
  localparam int PW     = 2 * WORD_W + 1;
  localparam int QW     = PW - SHIFT;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
  localparam logic [WORD_W:0]   RECIP = RECIP_FULL[WORD_W:0];
  localparam logic [MW_W-1:0]   MEMC  = MW_W'(MEM_WORDS);
  localparam logic [WORD_W-1:0] MEMD  = WORD_W'(MEM_WORDS);

  logic [XLEN-1:0]      mem [MEM_WORDS];
  logic [WORD_W-1:0]    word2;
  logic [WORD_W-1:0]    word3;
  logic [PW-1:0]        prod3;
  logic [QW-1:0]        quot;
  logic [QW+MW_W-1:0]   qc;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    rem_fix;
  logic [MIDX_W-1:0]    idx3;
  logic                 clearing;
  logic [MIDX_W-1:0]    clr_idx;

  // Address pipeline: take word address, then multiply by the reciprocal
  always_ff @(posedge clk) begin
    if (ctl.adv2) word2 <= addr[31:2];
    if (ctl.adv3) begin
      word3 <= word2;
      prod3 <= PW'(word2) * PW'(RECIP);
    end
  end

  // Remainder with a final correction step
  always_comb begin
    quot    = prod3[PW-1:SHIFT];
    qc      = (QW+MW_W)'(quot) * (QW+MW_W)'(MEMC);
    rem     = word3 - qc[WORD_W-1:0];
    rem_fix = (rem >= MEMD) ? rem - MEMD : rem;
    idx3    = rem_fix[MIDX_W-1:0];
  end

  // Clearing pass after reset, one word a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == MIDX_W'(MEM_WORDS - 1)) clearing <= 1'b0;
    end
  end

  assign clear_done = !clearing;

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (ctl.adv4 && ctl.store) begin
      mem[idx3] <= wdata;
    end
    if (ctl.adv4 && ctl.load) begin
      mem_q <= mem[idx3];
    end
  end

endmodule

// ===== hdl/rv32e_subset_single_cycle_core.sv =====
// An accepted item moves from the instruction register through s2 and s3 to s4, which drives m_tdata.
// Throughput: one item per cycle while m_tready is high; an item that reads the register a load
// ahead of it writes waits until the load data leaves the data memory.
// Reset clears the pc, registers, pipeline and then runs a clearing pass over the MEM_WORDS words of
// the data memory, during which s_tready stays low.
module rv32e_subset_single_cycle_core #(
  parameter int MEM_WORDS = 4096,
  parameter int REG_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,  // [31:0] instruction
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata   // [31:0] fetch_address, [32] reg_write, [36:33] reg_index,
                                 // [68:37] reg_value, [69] mem_write, [101:70] mem_address,
                                 // [133:102] mem_value, [135:134] zero
);
  import rvsc_pkg::*;

  localparam int RIDX_W = $clog2(REG_COUNT);

  function automatic logic [RIDX_W-1:0] rsel(input logic [4:0] f);
    logic [5:0] w;
    begin
      w = {1'b0, f};
      if (w >= 6'(REG_COUNT)) w = w - 6'(REG_COUNT);
      return w[RIDX_W-1:0];
    end
  endfunction

  logic              accept;
  logic              clear_done;
  logic              hazard;
  logic              en2, en3, en4;
  logic              mv1, mv2, mv3, out_take;
  logic              v1, v2, v3, v4;
  logic [31:0]       pc;
  logic [31:0]       inst1;
  logic [RIDX_W-1:0] rs1_1, rs2_1, rd_1;
  logic [RIDX_W-1:0] rd2, rd3, rd4;
  logic [31:0]       op_a, op_b;
  exec_res_t         res, s2, s3, s4;
  fwd_t              f2, f3, f4;
  dmem_ctl_t         dctl;
  logic [31:0]       mem_q;
  logic [31:0]       wb_value;
  logic              rf_we;

  // Stage advance: a stage moves when the one after it is empty or moving
  assign out_take = v4 && m_tready;
  assign en4      = !v4 || m_tready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign mv3      = v3 && en4;
  assign mv2      = v2 && en3;
  assign mv1      = v1 && en2 && !hazard;
  assign s_tready = clear_done && (!v1 || (en2 && !hazard));
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      pc <= '0;
    end else begin
      if (accept)   v1 <= 1'b1;
      else if (mv1) v1 <= 1'b0;
      if (mv1)      v2 <= 1'b1;
      else if (mv2) v2 <= 1'b0;
      if (mv2)      v3 <= 1'b1;
      else if (mv3) v3 <= 1'b0;
      if (mv3)           v4 <= 1'b1;
      else if (out_take) v4 <= 1'b0;
      if (mv1) pc <= res.fetch_address;
    end
  end

  // Hold the instruction and its register indices
  always_ff @(posedge clk) begin
    if (accept) begin
      inst1 <= s_tdata;
      rs1_1 <= rsel(s_tdata[19:15]);
      rs2_1 <= rsel(s_tdata[24:20]);
      rd_1  <= rsel(s_tdata[11:7]);
    end
  end

  // Advance payload down the pipeline
  always_ff @(posedge clk) begin
    if (mv1) begin
      s2  <= res;
      rd2 <= res.reg_write ? rd_1 : '0;
    end
    if (mv2) begin
      s3  <= s2;
      rd3 <= rd2;
    end
    if (mv3) begin
      s4  <= s3;
      rd4 <= rd3;
    end
  end

  assign wb_value = s4.is_load ? mem_q : s4.reg_value;
  assign rf_we    = out_take && s4.reg_write;

  // Forwarding views of the later stages
  always_comb begin
    f2.hit_a   = v2 && s2.reg_write && rd2 == rs1_1;
    f2.hit_b   = v2 && s2.reg_write && rd2 == rs2_1;
    f2.pending = s2.is_load;
    f2.value   = s2.reg_value;
    f3.hit_a   = v3 && s3.reg_write && rd3 == rs1_1;
    f3.hit_b   = v3 && s3.reg_write && rd3 == rs2_1;
    f3.pending = s3.is_load;
    f3.value   = s3.reg_value;
    f4.hit_a   = v4 && s4.reg_write && rd4 == rs1_1;
    f4.hit_b   = v4 && s4.reg_write && rd4 == rs2_1;
    f4.pending = 1'b0;
    f4.value   = wb_value;
  end

  rvsc_regfile #(.REG_COUNT(REG_COUNT)) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .rs1_in  (rsel(s_tdata[19:15])),
    .rs2_in  (rsel(s_tdata[24:20])),
    .rs1_q   (rs1_1),
    .rs2_q   (rs2_1),
    .wr_en   (rf_we),
    .wr_idx  (rd4),
    .wr_data (wb_value),
    .op_a    (op_a),
    .op_b    (op_b)
  );

  logic exec_hazard;

  rvsc_execute u_execute (
    .inst    (inst1),
    .pc      (pc),
    .op_a    (op_a),
    .op_b    (op_b),
    .rd_zero (rd_1 == '0),
    .f2      (f2),
    .f3      (f3),
    .f4      (f4),
    .res     (res),
    .hazard  (exec_hazard)
  );

  assign hazard = v1 && exec_hazard;

  always_comb begin
    dctl.adv2  = mv1;
    dctl.adv3  = mv2;
    dctl.adv4  = mv3;
    dctl.load  = s3.is_load;
    dctl.store = s3.mem_write;
  end

  rvsc_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
    .clk        (clk),
    .rst        (rst),
    .ctl        (dctl),
    .addr       (res.mem_address),
    .wdata      (s3.mem_value),
    .mem_q      (mem_q),
    .clear_done (clear_done)
  );

  // Result item
  assign m_tvalid = v4;
  assign m_tdata  = {2'b00, s4.mem_value, s4.mem_address, s4.mem_write, wb_value,
                     4'(rd4), s4.reg_write, s4.fetch_address};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rvsc_pkg::*;

  localparam int MEM_WORDS = 4096;
  localparam int REG_COUNT = 16;
  // An opcode the core does not decode
  localparam logic [6:0] OPC_UNUSED = 7'b1111011;

  // One retired instruction as seen on the result stream
  typedef struct {
    logic [31:0] fetch_address;
    logic        reg_write;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [31:0] mem_value;
  } retire_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;

  // Architectural state of the core as predicted here
  logic [31:0] arch_pc;
  logic [31:0] arch_regs [REG_COUNT];
  logic [31:0] data_words [MEM_WORDS];

  logic [31:0] pending_insns [$];
  retire_t     expected_retires [$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit rx_hold = 1'b0;
  int errors = 0;

  rv32e_subset_single_cycle_core #(
    .MEM_WORDS(MEM_WORDS),
    .REG_COUNT(REG_COUNT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch %s: got %08h, expected %08h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int word_slot(input logic [31:0] addr);
    return int'(addr[31:2] % MEM_WORDS);
  endfunction

  // Execute one instruction against the predicted state and return what it retires
  function automatic retire_t retire_insn(input logic [31:0] insn);
    retire_t     r;
    logic [3:0]  rd;
    logic [31:0] a, b, imm_i, imm_s, next_pc, wval;
    logic        wr;
    rd = insn[10:7];
    a = arch_regs[insn[18:15]];
    b = arch_regs[insn[23:20]];
    imm_i = {{20{insn[31]}}, insn[31:20]};
    imm_s = {{20{insn[31]}}, insn[31:25], insn[11:7]};
    next_pc = arch_pc + 32'd4;
    wr = 1'b0;
    wval = '0;
    r.mem_write = 1'b0;
    r.mem_address = '0;
    r.mem_value = '0;
    case (insn[6:0])
      OPC_OPIMM: begin
        wr = 1'b1;
        wval = a + imm_i;
      end
      OPC_OP: begin
        wr = 1'b1;
        wval = a + b;
      end
      OPC_LUI: begin
        wr = 1'b1;
        wval = {insn[31:12], 12'h000};
      end
      OPC_JALR: begin
        wr = 1'b1;
        wval = arch_pc + 32'd4;
        next_pc = (a + imm_i) & ~32'd1;
      end
      OPC_LOAD: begin
        wr = 1'b1;
        r.mem_address = a + imm_i;
        wval = data_words[word_slot(r.mem_address)];
      end
      OPC_STORE: begin
        r.mem_write = 1'b1;
        r.mem_address = a + imm_s;
        r.mem_value = b;
        data_words[word_slot(r.mem_address)] = b;
      end
      default: ;
    endcase
    // Register zero swallows its writes
    if (rd == 4'd0) wr = 1'b0;
    if (wr) begin
      arch_regs[rd] = wval;
    end else begin
      wval = '0;
      rd = 4'd0;
    end
    arch_pc = next_pc;
    r.fetch_address = next_pc;
    r.reg_write = wr;
    r.reg_index = rd;
    r.reg_value = wval;
    return r;
  endfunction

  function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [4:0] rd,
                                        input logic [4:0] rs1, input logic [11:0] imm);
    return {imm, rs1, 3'b000, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [4:0] rs1, input logic [4:0] rs2,
                                        input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, 3'b010, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_r(input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [4:0] rs2);
    return {7'b0000000, rs2, rs1, 3'b000, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] enc_u(input logic [4:0] rd, input logic [19:0] imm);
    return {imm, rd, OPC_LUI};
  endfunction

  // Mostly well-formed instructions with random fields; loads and stores often
  // hit a small window so that reads find earlier writes
  function automatic logic [31:0] random_insn();
    logic [31:0] w;
    logic [11:0] imm;
    int          pick;
    w = $urandom;
    pick = $urandom_range(0, 99);
    imm = 12'($urandom_range(0, 255));
    if (pick < 8 || pick >= 92) return w;
    if (pick < 26) w[6:0] = OPC_OPIMM;
    else if (pick < 38) w[6:0] = OPC_OP;
    else if (pick < 48) w[6:0] = OPC_LUI;
    else if (pick < 80) begin
      w[6:0] = (pick < 63) ? OPC_LOAD : OPC_STORE;
      if ($urandom_range(0, 2) != 0) begin
        w[19] = 1'($urandom_range(0, 1));
        w[18:15] = 4'd0;
        if (pick < 63) begin
          w[31:20] = imm;
        end else begin
          w[31:25] = imm[11:5];
          w[11:7] = imm[4:0];
        end
      end
    end else w[6:0] = OPC_JALR;
    return w;
  endfunction

  // Driver: offer the next pending instruction, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_retires.push_back(retire_insn(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (pending_insns.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_insns.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each retired item with the oldest prediction
  always @(posedge clk) begin : monitor
    retire_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.fetch_address = m_tdata[31:0];
        got.reg_write = m_tdata[32];
        got.reg_index = m_tdata[36:33];
        got.reg_value = m_tdata[68:37];
        got.mem_write = m_tdata[69];
        got.mem_address = m_tdata[101:70];
        got.mem_value = m_tdata[133:102];
        if (expected_retires.size() == 0) begin
          report_mismatch("result with nothing expected", got.fetch_address, '0);
        end else begin
          want = expected_retires.pop_front();
          if (got.fetch_address !== want.fetch_address)
            report_mismatch("fetch_address", got.fetch_address, want.fetch_address);
          if (got.reg_write !== want.reg_write)
            report_mismatch("reg_write", 32'(got.reg_write), 32'(want.reg_write));
          if (got.reg_index !== want.reg_index)
            report_mismatch("reg_index", 32'(got.reg_index), 32'(want.reg_index));
          if (got.reg_value !== want.reg_value)
            report_mismatch("reg_value", got.reg_value, want.reg_value);
          if (got.mem_write !== want.mem_write)
            report_mismatch("mem_write", 32'(got.mem_write), 32'(want.mem_write));
          if (got.mem_address !== want.mem_address)
            report_mismatch("mem_address", got.mem_address, want.mem_address);
          if (got.mem_value !== want.mem_value)
            report_mismatch("mem_value", got.mem_value, want.mem_value);
        end
      end
      m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Hold the sender until everything offered has retired
  task automatic wait_drained();
    while (pending_insns.size() != 0 || s_tvalid || expected_retires.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_random(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) pending_insns.push_back(random_insn());
    wait_drained();
  endtask

  initial begin
    arch_pc = '0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (data_words[i]) data_words[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: immediate extremes, register zero, index wrap, memory wrap, jumps
    pending_insns.push_back(enc_i(OPC_OPIMM, 5'd1, 5'd0, 12'hFFF));
    pending_insns.push_back(enc_i(OPC_OPIMM, 5'd2, 5'd0, 12'h7FF));
    pending_insns.push_back(enc_r(5'd3, 5'd1, 5'd2) | 32'h4000_0000);
    pending_insns.push_back(enc_u(5'd4, 20'hFFFFF));
    pending_insns.push_back(enc_i(OPC_OPIMM, 5'd0, 5'd1, 12'h005));
    pending_insns.push_back(enc_i(OPC_OPIMM, 5'd17, 5'd17, 12'h001) | 32'h0000_7000);
    pending_insns.push_back(enc_s(5'd0, 5'd1, 12'h7FC));
    pending_insns.push_back(enc_s(5'd0, 5'd2, 12'hFFC));
    pending_insns.push_back(enc_i(OPC_LOAD, 5'd5, 5'd0, 12'hFFC));
    pending_insns.push_back(enc_i(OPC_LOAD, 5'd6, 5'd0, 12'h7FF));
    pending_insns.push_back(enc_r(5'd7, 5'd5, 5'd6));
    pending_insns.push_back(enc_s(5'd4, 5'd3, 12'h010));
    pending_insns.push_back(enc_s(5'd0, 5'd0, 12'h020));
    pending_insns.push_back(enc_i(OPC_LOAD, 5'd8, 5'd4, 12'h010));
    pending_insns.push_back(enc_i(OPC_LOAD, 5'd9, 5'd0, 12'h400));
    pending_insns.push_back(enc_i(OPC_JALR, 5'd10, 5'd1, 12'h003));
    pending_insns.push_back(enc_i(OPC_JALR, 5'd1, 5'd1, 12'h000));
    pending_insns.push_back(enc_i(OPC_JALR, 5'd0, 5'd2, 12'h800));
    pending_insns.push_back(32'hFFFF_FFFF);
    pending_insns.push_back(32'h0000_0000);
    pending_insns.push_back(enc_i(OPC_UNUSED, 5'd3, 5'd1, 12'h123));
    pending_insns.push_back(enc_u(5'd15, 20'h12345));
    pending_insns.push_back(enc_r(5'd15, 5'd15, 5'd31));
    pending_insns.push_back(enc_u(5'd0, 20'hABCDE));
    pending_insns.push_back(enc_i(OPC_LOAD, 5'd11, 5'd7, 12'h000) | 32'h0000_5000);
    wait_drained();

    // Back-pressure: hold the result side off while the sender keeps offering
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
      end
    join_none
    run_random(300, 0, 0);
    run_random(300, 81, 0);
    run_random(300, 0, 81);
    run_random(300, 21, 21);

    repeat (20) @(negedge clk);
    if (expected_retires.size() != 0)
      report_mismatch("results never seen", expected_retires.size(), '0);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
